[src/zncc_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the zncc window correlator
// no dependencies

package zncc_pkg;

   localparam int MAX_RADIUS = 7;
   localparam int PIXEL_BITS = 8;
   localparam int RAD_W      = 3;
   localparam int SPAN_W     = RAD_W + 1;
   localparam int CNT_W      = 8;
   localparam int SUM_W      = 16;
   localparam int SQ_W       = 24;
   localparam int CORR_W     = 16;
   localparam int CSR_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int MUL_W      = 32;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int DIFF_W     = MUL_W + 2;
   localparam int ROOT_W     = 15;
   localparam int QUO_BITS   = 29;
   localparam int QUO_W      = 2 * ROOT_W;
   localparam int ITER_W     = 5;
   localparam int CORR_ONE   = 16384;
   localparam int WIN_MAX    = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_X  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_Y  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd2;

   localparam logic [RAD_W-1:0]  RADIUS_RESET    = 3'd2;
   localparam logic [CSR_W-1:0]  THRESHOLD_RESET = 16'd8192;

   typedef struct packed {
      logic busy;
      logic done;
   } zncc_root_status_type;

endpackage

[src/zncc_root_unit.sv]
`timescale 1ns / 1ps
// shared divide and square root unit: root = isqrt(floor(2^28 * sq_num / var_prod))
// depends on zncc_pkg

module zncc_root_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [zncc_pkg::PROD_W-1:0]          sq_num,
   input  logic [zncc_pkg::PROD_W-1:0]          var_prod,
   output logic [zncc_pkg::ROOT_W-1:0]          root,
   output zncc_pkg::zncc_root_status_type       status
);
   import zncc_pkg::*;

   localparam int OPD_W = PROD_W + 1;
   localparam int SUB_W = PROD_W + 2;
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_DIV  = 2'd1;
   localparam logic [1:0] PH_SQRT = 2'd2;
   localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(QUO_BITS - 1);
   localparam logic [ITER_W-1:0] SQRT_LAST = ITER_W'(ROOT_W - 1);

   logic [1:0]        phase_ff, phase_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W-1:0] rem_ff, rem_in;
   logic [PROD_W-1:0] den_ff, den_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic              lsb_ff, lsb_in;
   logic              done_ff, done_in;

   logic [OPD_W-1:0]  opa, opb;
   logic [SUB_W-1:0]  diff;
   logic              ge;

   // one subtractor serves both the divide and the root steps
   always_comb begin
      if (phase_ff == PH_SQRT) begin
         opa = {rem_ff[PROD_W-2:0], quo_ff[QUO_W-1 -: 2]};
         opb = OPD_W'({root_ff, 2'b01});
      end else begin
         opa = {rem_ff, (cnt_ff == DIV_LAST) & lsb_ff};
         opb = {1'b0, den_ff};
      end
      diff = {1'b0, opa} - {1'b0, opb};
      ge   = ~diff[SUB_W-1];
   end

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      root_in  = root_ff;
      lsb_in   = lsb_ff;
      done_in  = 1'b0;
      if (phase_ff == PH_IDLE) begin
         if (start) begin
            // dividend is sq_num * 2^28, top part is sq_num >> 1
            rem_in   = {1'b0, sq_num[PROD_W-1:1]};
            lsb_in   = sq_num[0];
            den_in   = var_prod;
            quo_in   = '0;
            cnt_in   = DIV_LAST;
            phase_in = PH_DIV;
         end
      end else if (phase_ff == PH_DIV) begin
         rem_in = ge ? diff[PROD_W-1:0] : opa[PROD_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], ge};
         if (cnt_ff == '0) begin
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = SQRT_LAST;
            phase_in = PH_SQRT;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end else begin
         rem_in  = ge ? diff[PROD_W-1:0] : opa[PROD_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], ge};
         quo_in  = {quo_ff[QUO_W-3:0], 2'b00};
         if (cnt_ff == '0) begin
            phase_in = PH_IDLE;
            done_in  = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      root_ff <= root_in;
      lsb_ff  <= lsb_in;
   end

   assign root        = root_ff;
   assign status.busy = (phase_ff != PH_IDLE);
   assign status.done = done_ff;

endmodule

[src/zncc_window_correlator.sv]
`timescale 1ns / 1ps
// zncc window correlator: one pixel pair per request, one correlation per window
// depends on zncc_pkg and zncc_root_unit
// non-closing request: accepted in the idle state, ready again the next cycle
// closing request: 10 multiplier, 29 divide, 15 root steps; a flat window skips divide and root
// no request is taken while a window is finished, until its result enters the output register
// sync active-high reset clears sums, count, sequencer, output valid; radii 2, threshold 8192

module zncc_window_correlator (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,   // left_pixel, right_pixel
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,   // correlation
   output logic [1:0]                        rsp_tuser,   // above_threshold, flat_window
   // register writes
   input  logic                              csr_we,
   input  logic [zncc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [zncc_pkg::CSR_W-1:0]        csr_wdata
);
   import zncc_pkg::*;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_ROOT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   // multiplier steps
   localparam logic [3:0] MS_NX    = 4'd0;
   localparam logic [3:0] MS_SLSR  = 4'd1;
   localparam logic [3:0] MS_NLSQ  = 4'd2;
   localparam logic [3:0] MS_SLSL  = 4'd3;
   localparam logic [3:0] MS_NRSQ  = 4'd4;
   localparam logic [3:0] MS_SRSR  = 4'd5;
   localparam logic [3:0] MS_VR    = 4'd6;
   localparam logic [3:0] MS_FLAT  = 4'd7;
   localparam logic [3:0] MS_DEN   = 4'd8;
   localparam logic [3:0] MS_START = 4'd9;

   logic [1:0]             state_ff, state_in;
   logic [3:0]             mstep_ff, mstep_in;

   logic [RAD_W-1:0]       rx_ff, rx_in;
   logic [RAD_W-1:0]       ry_ff, ry_in;
   logic [CSR_W-1:0]       thr_ff, thr_in;

   // running sums of the current window
   logic [SUM_W-1:0]       lsum_ff, lsum_in;
   logic [SUM_W-1:0]       rsum_ff, rsum_in;
   logic [SQ_W-1:0]        lsq_ff, lsq_in;
   logic [SQ_W-1:0]        rsq_ff, rsq_in;
   logic [SQ_W-1:0]        xsum_ff, xsum_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;

   // statistics datapath
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [MUL_W-1:0]       hold_ff, hold_in;
   logic signed [DIFF_W-1:0] num_ff, num_in;
   logic signed [DIFF_W-1:0] vl_ff, vl_in;
   logic signed [DIFF_W-1:0] vr_ff, vr_in;
   logic [PROD_W-1:0]      den_ff, den_in;
   logic [ROOT_W-1:0]      q_ff, q_in;
   logic                   flat_ff, flat_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CORR_W-1:0]      rsp_corr_ff, rsp_corr_in;
   logic                   rsp_above_ff, rsp_above_in;
   logic                   rsp_flat_ff, rsp_flat_in;

   logic [PIXEL_BITS-1:0]  lpix, rpix;
   logic [RAD_W-1:0]       rx_sat, ry_sat;
   logic [CNT_W-1:0]       win_len;
   logic                   req_take, rsp_free, is_flat, root_start;
   logic [MUL_W-1:0]       mul_a, mul_b;
   logic signed [DIFF_W-1:0] sub_res;
   logic signed [DIFF_W-1:0] num_abs;
   logic [ROOT_W-1:0]      root_val, root_cap;
   logic signed [CORR_W-1:0] corr_val;
   zncc_root_status_type   root_stat;

   assign lpix = req_tdata[PIXEL_BITS-1:0];
   assign rpix = req_tdata[2*PIXEL_BITS-1:PIXEL_BITS];

   // window length from saturated radii, span is 2r+1
   always_comb begin
      rx_sat  = (rx_ff > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : rx_ff;
      ry_sat  = (ry_ff > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : ry_ff;
      win_len = CNT_W'({rx_sat, 1'b1}) * CNT_W'({ry_sat, 1'b1});
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid & req_tready;
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;
   assign is_flat    = (vl_ff <= 0) | (vr_ff <= 0);
   assign root_start = (state_ff == ST_MUL) & (mstep_ff == MS_START);

   // shared multiplier operand select
   always_comb begin
      unique case (mstep_ff)
         MS_NX: begin
            mul_a = MUL_W'(cnt_ff);
            mul_b = MUL_W'(xsum_ff);
         end
         MS_SLSR: begin
            mul_a = MUL_W'(lsum_ff);
            mul_b = MUL_W'(rsum_ff);
         end
         MS_NLSQ: begin
            mul_a = MUL_W'(cnt_ff);
            mul_b = MUL_W'(lsq_ff);
         end
         MS_SLSL: begin
            mul_a = MUL_W'(lsum_ff);
            mul_b = MUL_W'(lsum_ff);
         end
         MS_NRSQ: begin
            mul_a = MUL_W'(cnt_ff);
            mul_b = MUL_W'(rsq_ff);
         end
         MS_SRSR: begin
            mul_a = MUL_W'(rsum_ff);
            mul_b = MUL_W'(rsum_ff);
         end
         MS_FLAT: begin
            mul_a = vl_ff[MUL_W-1:0];
            mul_b = vr_ff[MUL_W-1:0];
         end
         MS_DEN: begin
            mul_a = num_abs[MUL_W-1:0];
            mul_b = num_abs[MUL_W-1:0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // first product term minus second, both below 2^32
   assign sub_res  = $signed({2'b00, hold_ff}) - $signed({2'b00, prod_ff[MUL_W-1:0]});
   assign num_abs  = num_ff[DIFF_W-1] ? -num_ff : num_ff;
   assign root_cap = (root_val > ROOT_W'(CORR_ONE)) ? ROOT_W'(CORR_ONE) : root_val;
   assign corr_val = num_ff[DIFF_W-1] ? -$signed(CORR_W'(q_ff)) : $signed(CORR_W'(q_ff));

   always_comb begin
      state_in     = state_ff;
      mstep_in     = mstep_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      thr_in       = thr_ff;
      lsum_in      = lsum_ff;
      rsum_in      = rsum_ff;
      lsq_in       = lsq_ff;
      rsq_in       = rsq_ff;
      xsum_in      = xsum_ff;
      cnt_in       = cnt_ff;
      prod_in      = mul_a * mul_b;
      hold_in      = hold_ff;
      num_in       = num_ff;
      vl_in        = vl_ff;
      vr_in        = vr_ff;
      den_in       = den_ff;
      q_in         = q_ff;
      flat_in      = flat_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_corr_in  = rsp_corr_ff;
      rsp_above_in = rsp_above_ff;
      rsp_flat_in  = rsp_flat_ff;

      // register writes, unused index ignored
      if (csr_we) begin
         unique case (csr_index)
            CSR_RADIUS_X:  rx_in  = csr_wdata[RAD_W-1:0];
            CSR_RADIUS_Y:  ry_in  = csr_wdata[RAD_W-1:0];
            CSR_THRESHOLD: thr_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               // accumulate the pair; sums wrap at their widths
               lsum_in = lsum_ff + SUM_W'(lpix);
               rsum_in = rsum_ff + SUM_W'(rpix);
               lsq_in  = lsq_ff + SQ_W'(lpix) * SQ_W'(lpix);
               rsq_in  = rsq_ff + SQ_W'(rpix) * SQ_W'(rpix);
               xsum_in = xsum_ff + SQ_W'(lpix) * SQ_W'(rpix);
               cnt_in  = cnt_ff + 1'b1;
               // window closes once the count reaches the current length
               if ((cnt_ff + 1'b1) >= win_len) begin
                  state_in = ST_MUL;
                  mstep_in = MS_NX;
               end
            end
         end
         ST_MUL: begin
            mstep_in = mstep_ff + 1'b1;
            unique case (mstep_ff)
               MS_SLSR, MS_SLSL, MS_SRSR: hold_in = prod_ff[MUL_W-1:0];
               MS_NLSQ: num_in = sub_res;
               MS_NRSQ: vl_in  = sub_res;
               MS_VR:   vr_in  = sub_res;
               MS_FLAT: begin
                  // variance not above zero on either side: no root needed
                  if (is_flat) begin
                     flat_in  = 1'b1;
                     q_in     = '0;
                     state_in = ST_DONE;
                  end
               end
               MS_DEN:   den_in   = prod_ff;
               MS_START: state_in = ST_ROOT;
               default: ;
            endcase
         end
         ST_ROOT: begin
            if (root_stat.done) begin
               q_in     = root_cap;
               flat_in  = 1'b0;
               state_in = ST_DONE;
            end
         end
         default: begin
            // hand the result over and start a fresh window
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_corr_in  = flat_ff ? '0 : corr_val;
               rsp_above_in = ~flat_ff & (corr_val > $signed(thr_ff));
               rsp_flat_in  = flat_ff;
               lsum_in      = '0;
               rsum_in      = '0;
               lsq_in       = '0;
               rsq_in       = '0;
               xsum_in      = '0;
               cnt_in       = '0;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mstep_ff     <= MS_NX;
         rx_ff        <= RADIUS_RESET;
         ry_ff        <= RADIUS_RESET;
         thr_ff       <= THRESHOLD_RESET;
         lsum_ff      <= '0;
         rsum_ff      <= '0;
         lsq_ff       <= '0;
         rsq_ff       <= '0;
         xsum_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mstep_ff     <= mstep_in;
         rx_ff        <= rx_in;
         ry_ff        <= ry_in;
         thr_ff       <= thr_in;
         lsum_ff      <= lsum_in;
         rsum_ff      <= rsum_in;
         lsq_ff       <= lsq_in;
         rsq_ff       <= rsq_in;
         xsum_ff      <= xsum_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff      <= prod_in;
      hold_ff      <= hold_in;
      num_ff       <= num_in;
      vl_ff        <= vl_in;
      vr_ff        <= vr_in;
      den_ff       <= den_in;
      q_ff         <= q_in;
      flat_ff      <= flat_in;
      rsp_corr_ff  <= rsp_corr_in;
      rsp_above_ff <= rsp_above_in;
      rsp_flat_ff  <= rsp_flat_in;
   end

   // divide and root of the normalized square
   zncc_root_unit u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .sq_num   (prod_ff),
      .var_prod (den_ff),
      .root     (root_val),
      .status   (root_stat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_corr_ff;
   assign rsp_tuser  = {rsp_flat_ff, rsp_above_ff};

   // root unit only finishes while the sequencer waits for it
   a_root_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      root_stat.done |-> (state_ff == ST_ROOT))
      else $error("root unit finished outside its wait state");

   // root unit is idle whenever the sequencer takes requests
   a_root_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !root_stat.busy)
      else $error("root unit busy while taking requests");

   // pair count never passes the largest window
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(WIN_MAX))
      else $error("pair count beyond largest window");

   // a flat window gives zero correlation and never passes
   a_flat_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_flat_ff) |-> (!rsp_above_ff && rsp_corr_ff == '0))
      else $error("flat window with nonzero result");

   // correlation stays within plus or minus one
   a_corr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($signed(rsp_corr_ff) <= $signed(CORR_W'(CORR_ONE)) &&
                        $signed(rsp_corr_ff) >= -$signed(CORR_W'(CORR_ONE))))
      else $error("correlation out of range");

endmodule
